@@ hw/rtl/sddm_pkg.sv @@
// Shared types, constants and controller/datapath interface structs for the
// stick-to-differential-drive mixer. No dependencies.

package sddm_pkg;

   localparam int TIME_BITS_DEF = 48;
   localparam int AXIS_W        = 11;
   localparam int CMD_W         = 9;
   localparam int DZ_W          = 8;
   localparam int TMO_W         = 24;
   localparam int CSR_IDX_W     = 1;
   localparam int MIX_W         = 10;
   localparam int DIV_NUM_W     = 17;
   localparam int DIV_DEN_W     = 10;
   localparam int DIV_Q_W       = 8;
   localparam int CMD_MAX       = 255;

   localparam logic [DZ_W-1:0]  DEADZONE_RST = 8'd50;
   localparam logic [TMO_W-1:0] TIMEOUT_RST  = 24'd300000;

   localparam logic signed [AXIS_W-1:0] AXIS_LOW     = -11'sd512;
   localparam logic signed [AXIS_W-1:0] AXIS_HIGH    = 11'sd512;
   localparam logic signed [AXIS_W-1:0] AXIS_POS_MAX = 11'sd511;
   localparam logic [DIV_DEN_W-1:0]     TOP_NEG      = 10'd512;
   localparam logic [DIV_DEN_W-1:0]     TOP_POS      = 10'd511;

   typedef enum logic [1:0] {
      OP_REPORT = 2'd0,
      OP_TICK   = 2'd1,
      OP_STOP   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEADZONE = 1'd0,
      CSR_TIMEOUT  = 1'd1
   } csr_idx_type;

   typedef enum logic [1:0] {
      SEL_X = 2'd0,
      SEL_Y = 2'd1,
      SEL_L = 2'd2,
      SEL_R = 2'd3
   } div_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIV_X,
      ST_DIV_Y,
      ST_MIX,
      ST_CHECK,
      ST_DIV_L,
      ST_DIV_R,
      ST_COMMIT,
      ST_EMIT_FIRST,
      ST_EMIT_LAST
   } state_type;

   typedef struct packed {
      logic        capture;
      logic        stop;
      logic        div_start;
      div_sel_type div_sel;
      logic        div_store;
      logic        mix;
      logic        commit;
      logic        emit;
      logic        emit_last;
   } ctrl_cmd_type;

   typedef struct packed {
      op_type op;
      logic   bad_report;
      logic   timed_out;
      logic   usable;
      logic   div_done;
      logic   peak_over;
      logic   out_free;
   } dp_status_type;

endpackage

@@ hw/rtl/stick_to_differential_drive_mixer_core.sv @@
// Top level of the stick-to-differential-drive mixer: controller plus datapath.
// Depends on sddm_pkg, sddm_ctrl, sddm_datapath.
//
// req_ channel: one word per joystick report, heartbeat tick or stop command,
// taken when req_valid is high and req_stall is low. rsp_ channel: motor
// command words, held in an output register until the receiver drops
// rsp_stall. A good report yields no word; a tick yields one word, or two
// (stop then heartbeat, rsp_last_of_run low then high) when the commands are
// usable and the timeout has run out; bad reports and stop commands yield a
// single 0,0 word. One word is worked on at a time: a good report runs two
// divisions on the shared one-bit-per-cycle divider for the axes, and two
// more for normalization when the mix exceeds full scale.
// A stalled receiver holds the result register; the block then waits in its
// emit step and keeps req_stall high until the word can be loaded.
// csr_ writes (index 0 deadzone, 1 timeout in microseconds) are taken on any
// cycle with csr_we high. Synchronous reset clears the held commands, the
// usable flag and the last good time, and restores deadzone 50 and timeout 300000.

module stick_to_differential_drive_mixer_core #(
   parameter int TIME_BITS = sddm_pkg::TIME_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [sddm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sddm_pkg::TMO_W-1:0]         csr_wdata,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_command,
   input  logic signed [sddm_pkg::AXIS_W-1:0] req_axis_x,
   input  logic signed [sddm_pkg::AXIS_W-1:0] req_axis_y,
   input  logic                               req_is_gamepad,
   input  logic [TIME_BITS-1:0]               req_now_us,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [sddm_pkg::CMD_W-1:0]  rsp_left_cmd,
   output logic signed [sddm_pkg::CMD_W-1:0]  rsp_right_cmd,
   output logic                               rsp_last_of_run
);
   import sddm_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   sddm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sddm_datapath #(
      .TIME_BITS (TIME_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_command     (req_command),
      .req_axis_x      (req_axis_x),
      .req_axis_y      (req_axis_y),
      .req_is_gamepad  (req_is_gamepad),
      .req_now_us      (req_now_us),
      .rsp_stall       (rsp_stall),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_left_cmd    (rsp_left_cmd),
      .rsp_right_cmd   (rsp_right_cmd),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // a stop word ahead of the heartbeat always carries zero commands
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> rsp_left_cmd == '0 && rsp_right_cmd == '0)
      else $error("non-final word with nonzero command");

   // commands stay within full scale
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_left_cmd != -9'sd256 && rsp_right_cmd != -9'sd256)
      else $error("command outside full scale");

   // one word in flight: an accepted word blocks the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word taken while busy");

   // the controller never issues stop and commit together
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.stop && cmd.commit))
      else $error("stop and commit in one cycle");

endmodule

@@ hw/rtl/sddm_div.sv @@
// Restoring divider, one quotient bit per cycle, quotient known to fit DIV_Q_W bits.
// Depends on sddm_pkg.

module sddm_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [sddm_pkg::DIV_NUM_W-1:0] num,
   input  logic [sddm_pkg::DIV_DEN_W-1:0] den,
   output logic                           done,
   output logic [sddm_pkg::DIV_Q_W-1:0]   quot
);
   import sddm_pkg::*;

   localparam int CNT_W = $clog2(DIV_Q_W + 1);

   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_Q_W-1:0]   sh_ff, sh_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   trial, diff;
   logic                 ge;

   always_comb begin
      trial   = {rem_ff, sh_ff[DIV_Q_W-1]};
      diff    = trial - {1'b0, den_ff};
      ge      = (trial >= {1'b0, den_ff});
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // high dividend bits already lie below den since the quotient fits
         rem_in  = DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]);
         sh_in   = num[DIV_Q_W-1:0];
         cnt_in  = CNT_W'(DIV_Q_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         sh_in  = {sh_ff[DIV_Q_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      if (start) begin
         den_ff <= den;
      end
   end

   assign done = done_ff;
   assign quot = sh_ff;

endmodule

@@ hw/rtl/sddm_datapath.sv @@
// Datapath: input capture, config registers, held motor state, axis scaling,
// mixing, peak normalization and the result output register.
// Depends on sddm_pkg and sddm_div.

module sddm_datapath #(
   parameter int TIME_BITS = sddm_pkg::TIME_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [sddm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [sddm_pkg::TMO_W-1:0]            csr_wdata,
   input  logic [1:0]                            req_command,
   input  logic signed [sddm_pkg::AXIS_W-1:0]    req_axis_x,
   input  logic signed [sddm_pkg::AXIS_W-1:0]    req_axis_y,
   input  logic                                  req_is_gamepad,
   input  logic [TIME_BITS-1:0]                  req_now_us,
   input  logic                                  rsp_stall,
   input  sddm_pkg::ctrl_cmd_type                cmd,
   output sddm_pkg::dp_status_type               status,
   output logic                                  rsp_valid,
   output logic signed [sddm_pkg::CMD_W-1:0]     rsp_left_cmd,
   output logic signed [sddm_pkg::CMD_W-1:0]     rsp_right_cmd,
   output logic                                  rsp_last_of_run
);
   import sddm_pkg::*;

   localparam int CMP_W = (TIME_BITS > TMO_W) ? TIME_BITS : TMO_W;

   // captured word
   op_type                   op_ff;
   logic signed [AXIS_W-1:0] x_ff, y_ff;
   logic                     gp_ff;
   logic [TIME_BITS-1:0]     now_ff;

   // config
   logic [DZ_W-1:0]  dz_ff;
   logic [TMO_W-1:0] tmo_ff;

   // held state
   logic                    usable_ff;
   logic signed [CMD_W-1:0] left_motor_ff, right_motor_ff;
   logic [TIME_BITS-1:0]    last_good_ff;

   // working registers
   logic signed [MIX_W-1:0] turn_ff, fwd_ff, l_ff, r_ff;
   logic [MIX_W-1:0]        peak_ff;
   div_sel_type             sel_ff;
   logic                    neg_ff;

   // output register
   logic                    rsp_valid_ff;
   logic signed [CMD_W-1:0] rsp_left_ff, rsp_right_ff;
   logic                    rsp_last_ff;

   // divider operands
   logic signed [AXIS_W-1:0] axis_sel, axis_clamp, axis_negv;
   logic                     axis_neg, axis_zone;
   logic [MIX_W-1:0]         axis_mag, axis_excess;
   logic [DIV_NUM_W:0]       axis_prod;
   logic [DIV_NUM_W-1:0]     axis_num;
   logic [DIV_DEN_W-1:0]     axis_den;
   logic signed [MIX_W-1:0]  mix_sel, mix_negv;
   logic                     mix_neg;
   logic [MIX_W-1:0]         mix_mag;
   logic [DIV_NUM_W:0]       mix_prod;
   logic                     use_axis;
   logic [DIV_NUM_W-1:0]     div_num;
   logic [DIV_DEN_W-1:0]     div_den;
   logic                     div_neg;
   logic                     div_done;
   logic [DIV_Q_W-1:0]       div_quot;
   logic                     res_neg;
   logic signed [MIX_W-1:0]  res_pos, res_val;

   // mixing
   logic signed [MIX_W-1:0] l_mix, r_mix, l_abs, r_abs;

   // timeout
   logic [TIME_BITS-1:0] elapsed;

   always_comb begin
      use_axis    = (cmd.div_sel == SEL_X) || (cmd.div_sel == SEL_Y);
      axis_sel    = (cmd.div_sel == SEL_X) ? x_ff : y_ff;
      axis_clamp  = (axis_sel > AXIS_POS_MAX) ? AXIS_POS_MAX : axis_sel;
      axis_neg    = axis_clamp[AXIS_W-1];
      axis_negv   = -axis_clamp;
      axis_mag    = axis_neg ? axis_negv[MIX_W-1:0] : axis_clamp[MIX_W-1:0];
      axis_zone   = (axis_mag <= MIX_W'(dz_ff));
      axis_excess = axis_mag - MIX_W'(dz_ff);
      // x * 255 as (x << 8) - x
      axis_prod   = {axis_excess, 8'd0} - (DIV_NUM_W + 1)'(axis_excess);
      axis_num    = axis_zone ? '0 : axis_prod[DIV_NUM_W-1:0];
      axis_den    = (axis_neg ? TOP_NEG : TOP_POS) - DIV_DEN_W'(dz_ff);

      mix_sel  = (cmd.div_sel == SEL_L) ? l_ff : r_ff;
      mix_neg  = mix_sel[MIX_W-1];
      mix_negv = -mix_sel;
      mix_mag  = mix_neg ? mix_negv : mix_sel;
      mix_prod = {mix_mag, 8'd0} - (DIV_NUM_W + 1)'(mix_mag);

      div_num = use_axis ? axis_num : mix_prod[DIV_NUM_W-1:0];
      div_den = use_axis ? axis_den : peak_ff;
      div_neg = use_axis ? axis_neg : mix_neg;

      // forward is the negated vertical value
      res_neg = neg_ff ^ (sel_ff == SEL_Y);
      res_pos = MIX_W'(div_quot);
      res_val = res_neg ? -res_pos : res_pos;

      l_mix = fwd_ff + turn_ff;
      r_mix = fwd_ff - turn_ff;
      l_abs = l_mix[MIX_W-1] ? -l_mix : l_mix;
      r_abs = r_mix[MIX_W-1] ? -r_mix : r_mix;

      elapsed = now_ff - last_good_ff;
   end

   sddm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= op_type'(req_command);
         x_ff   <= req_axis_x;
         y_ff   <= req_axis_y;
         gp_ff  <= req_is_gamepad;
         now_ff <= req_now_us;
      end
      if (cmd.div_start) begin
         sel_ff <= cmd.div_sel;
         neg_ff <= div_neg;
      end
      if (cmd.div_store) begin
         case (sel_ff)
            SEL_X:   turn_ff <= res_val;
            SEL_Y:   fwd_ff  <= res_val;
            SEL_L:   l_ff    <= res_val;
            SEL_R:   r_ff    <= res_val;
            default: ;
         endcase
      end
      if (cmd.mix) begin
         l_ff    <= l_mix;
         r_ff    <= r_mix;
         peak_ff <= (l_abs > r_abs) ? l_abs : r_abs;
      end
      if (cmd.emit) begin
         rsp_left_ff  <= left_motor_ff;
         rsp_right_ff <= right_motor_ff;
         rsp_last_ff  <= cmd.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dz_ff          <= DEADZONE_RST;
         tmo_ff         <= TIMEOUT_RST;
         usable_ff      <= 1'b0;
         left_motor_ff  <= '0;
         right_motor_ff <= '0;
         last_good_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_idx_type'(csr_index))
               CSR_DEADZONE: dz_ff  <= csr_wdata[DZ_W-1:0];
               CSR_TIMEOUT:  tmo_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.stop) begin
            usable_ff      <= 1'b0;
            left_motor_ff  <= '0;
            right_motor_ff <= '0;
         end else if (cmd.commit) begin
            usable_ff      <= 1'b1;
            left_motor_ff  <= l_ff[CMD_W-1:0];
            right_motor_ff <= r_ff[CMD_W-1:0];
            last_good_ff   <= now_ff;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      status.op         = op_ff;
      status.bad_report = !gp_ff || (x_ff < AXIS_LOW) || (x_ff > AXIS_HIGH) ||
                          (y_ff < AXIS_LOW) || (y_ff > AXIS_HIGH);
      status.timed_out  = CMP_W'(elapsed) >= CMP_W'(tmo_ff);
      status.usable     = usable_ff;
      status.div_done   = div_done;
      status.peak_over  = peak_ff > MIX_W'(CMD_MAX);
      status.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_cmd    = rsp_left_ff;
   assign rsp_right_cmd   = rsp_right_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

@@ hw/rtl/sddm_ctrl.sv @@
// Controller: sequences decode, up to four divisions, mixing, commit and emit.
// Depends on sddm_pkg.

module sddm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  sddm_pkg::dp_status_type status,
   output sddm_pkg::ctrl_cmd_type  cmd
);
   import sddm_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (status.op)
               OP_REPORT: begin
                  if (status.bad_report) begin
                     cmd.stop = 1'b1;
                     state_in = ST_EMIT_LAST;
                  end else begin
                     cmd.div_start = 1'b1;
                     cmd.div_sel   = SEL_X;
                     state_in      = ST_DIV_X;
                  end
               end
               OP_TICK: begin
                  if (status.usable && status.timed_out) begin
                     cmd.stop = 1'b1;
                     state_in = ST_EMIT_FIRST;
                  end else begin
                     state_in = ST_EMIT_LAST;
                  end
               end
               OP_STOP: begin
                  cmd.stop = 1'b1;
                  state_in = ST_EMIT_LAST;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_DIV_X: begin
            if (status.div_done) begin
               cmd.div_store = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel   = SEL_Y;
               state_in      = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            if (status.div_done) begin
               cmd.div_store = 1'b1;
               state_in      = ST_MIX;
            end
         end
         ST_MIX: begin
            cmd.mix  = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.peak_over) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = SEL_L;
               state_in      = ST_DIV_L;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_DIV_L: begin
            if (status.div_done) begin
               cmd.div_store = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel   = SEL_R;
               state_in      = ST_DIV_R;
            end
         end
         ST_DIV_R: begin
            if (status.div_done) begin
               cmd.div_store = 1'b1;
               state_in      = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_EMIT_FIRST: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_EMIT_LAST;
            end
         end
         ST_EMIT_LAST: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
